// ===== src/escaped_checksum_frame_encoder_assert.svh =====
// Assertion macros for the escaped checksum frame encoder.
`ifndef ESCAPED_CHECKSUM_FRAME_ENCODER_ASSERT_SVH
`define ESCAPED_CHECKSUM_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define ECFE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant, checked while out of reset.
`define ECFE_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error(msg);

`endif

// ===== src/ecfe_pkg.sv =====
// Package: constants and helpers for the escaped checksum frame encoder.
package ecfe_pkg;

  localparam int unsigned LENGTH_WIDTH_DEF = 16;
  localparam int unsigned MAX_BYTES        = 8;
  localparam int unsigned CNT_W            = $clog2(MAX_BYTES + 1);
  localparam int unsigned PIECES           = 5;

  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_ETX = 8'h03;
  localparam logic [7:0] CODE_ESC = 8'h1b;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  function automatic logic is_control(input logic [7:0] b);
    logic r;
    case (b)
      8'h02, 8'h03, 8'h05, 8'h06, 8'h11, 8'h1b: r = 1'b1;
      default:                                   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/escaped_checksum_frame_encoder.sv =====
// Top level: STX/ETX framer with byte stuffing and an 8-bit additive checksum.
//
//  channel  dir  tdata (low bit up)                     tuser      tlast
//  s_axis   in   frame_length[15:0], data_byte[23:16]   req_type   -
//  m_axis   out  out_byte[7:0]                          frame_done run_last
//
// An item is held in the input register, then its encoded bytes (0 to 8; none
// for dropped data) go into the result buffer in one pass and leave one per
// cycle while m_axis_tready is high. A new item is accepted while the input
// register is empty or moves on, which it does once the buffer drains.
// Reset clears the frame state and both valid stages; no clearing pass.
// Output stalls hold the buffer; the input register waits for it to empty.
`include "escaped_checksum_frame_encoder_assert.svh"

module escaped_checksum_frame_encoder #(
  parameter int unsigned LENGTH_WIDTH = ecfe_pkg::LENGTH_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // frame_length[15:0], data_byte[23:16]
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // frame_done
);

  localparam int unsigned MB = ecfe_pkg::MAX_BYTES;
  localparam int unsigned CW = ecfe_pkg::CNT_W;
  localparam int unsigned NP = ecfe_pkg::PIECES;

  // input register
  logic        in_valid_q, in_valid_d;
  logic        in_type_q;
  logic [15:0] in_len_q;
  logic [7:0]  in_data_q;

  // frame state
  logic                    frame_open_q, frame_open_d;
  logic [LENGTH_WIDTH-1:0] bytes_left_q, bytes_left_d;
  logic [7:0]              running_sum_q, running_sum_d;

  // result buffer, entry 0 is on the bus
  logic [7:0]    res_q [MB];
  logic [7:0]    res_d [MB];
  logic [CW-1:0] res_cnt_q, res_cnt_d;
  logic          res_done_q, res_done_d;

  logic s_acc, m_take, res_free, move;

  // encoder scratch
  logic [LENGTH_WIDTH-1:0] len_m;
  logic [15:0]             len16;
  logic [7:0]              sum_a, sum_t;
  logic [LENGTH_WIDTH-1:0] left_dec;
  logic                    closing, drop;
  logic [7:0]              pc_byte [NP];
  logic                    pc_en   [NP];
  logic                    pc_esc  [NP];
  logic [7:0]              nb      [MB];
  logic [CW-1:0]           ncnt;

  assign m_axis_tvalid = (res_cnt_q != '0);
  assign m_axis_tdata  = res_q[0];
  assign m_axis_tlast  = (res_cnt_q == CW'(1));
  assign m_axis_tuser  = res_done_q && (res_cnt_q == CW'(1));

  assign m_take   = m_axis_tvalid && m_axis_tready;
  assign res_free = (res_cnt_q == '0) || ((res_cnt_q == CW'(1)) && m_axis_tready);
  assign move     = in_valid_q && res_free;
  assign s_axis_tready = !in_valid_q || move;
  assign s_acc    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    len_m    = in_len_q[LENGTH_WIDTH-1:0];
    len16    = 16'(len_m);
    left_dec = bytes_left_q - LENGTH_WIDTH'(1);
    drop     = (in_type_q == ecfe_pkg::REQ_DATA) && !frame_open_q;
    if (in_type_q == ecfe_pkg::REQ_START) begin
      sum_a   = len16[7:0] + len16[15:8];
      closing = (len_m == '0);
    end else begin
      sum_a   = running_sum_q + in_data_q;
      closing = (left_dec == '0);
    end
    sum_t = sum_a + ecfe_pkg::CODE_ETX;

    for (int i = 0; i < NP; i++) begin
      pc_byte[i] = '0;
      pc_en[i]   = 1'b0;
      pc_esc[i]  = 1'b0;
    end
    if (in_type_q == ecfe_pkg::REQ_START) begin
      pc_byte[0] = ecfe_pkg::CODE_STX; pc_en[0] = 1'b1;
      pc_byte[1] = len16[7:0];         pc_en[1] = 1'b1; pc_esc[1] = 1'b1;
      pc_byte[2] = len16[15:8];        pc_en[2] = 1'b1; pc_esc[2] = 1'b1;
      pc_byte[3] = ecfe_pkg::CODE_ETX; pc_en[3] = closing;
      pc_byte[4] = sum_t;              pc_en[4] = closing; pc_esc[4] = 1'b1;
    end else begin
      pc_byte[0] = in_data_q;          pc_en[0] = !drop; pc_esc[0] = 1'b1;
      pc_byte[1] = ecfe_pkg::CODE_ETX; pc_en[1] = !drop && closing;
      pc_byte[2] = sum_t;              pc_en[2] = !drop && closing; pc_esc[2] = 1'b1;
    end

    // pack the pieces, stuffing control bytes
    for (int j = 0; j < MB; j++) nb[j] = '0;
    ncnt = '0;
    for (int i = 0; i < NP; i++) begin
      if (pc_en[i]) begin
        if (pc_esc[i] && ecfe_pkg::is_control(pc_byte[i])) begin
          nb[ncnt[2:0]]           = ecfe_pkg::CODE_ESC;
          nb[3'(ncnt + CW'(1))]   = ~pc_byte[i];
          ncnt                    = ncnt + CW'(2);
        end else begin
          nb[ncnt[2:0]] = pc_byte[i];
          ncnt          = ncnt + CW'(1);
        end
      end
    end
  end

  always_comb begin
    in_valid_d    = s_acc || (in_valid_q && !move);
    frame_open_d  = frame_open_q;
    bytes_left_d  = bytes_left_q;
    running_sum_d = running_sum_q;
    if (move && !drop) begin
      if (closing) begin
        frame_open_d  = 1'b0;
        bytes_left_d  = '0;
        running_sum_d = '0;
      end else begin
        frame_open_d  = 1'b1;
        bytes_left_d  = (in_type_q == ecfe_pkg::REQ_START) ? len_m : left_dec;
        running_sum_d = sum_a;
      end
    end
  end

  always_comb begin
    res_d      = res_q;
    res_cnt_d  = res_cnt_q;
    res_done_d = res_done_q;
    if (move && (ncnt != '0)) begin
      res_d      = nb;
      res_cnt_d  = ncnt;
      res_done_d = closing;
    end else if (m_take) begin
      for (int j = 0; j < MB - 1; j++) res_d[j] = res_q[j+1];
      res_d[MB-1] = '0;
      res_cnt_d   = res_cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      frame_open_q  <= 1'b0;
      bytes_left_q  <= '0;
      running_sum_q <= '0;
      res_cnt_q     <= '0;
      res_done_q    <= 1'b0;
    end else begin
      in_valid_q    <= in_valid_d;
      frame_open_q  <= frame_open_d;
      bytes_left_q  <= bytes_left_d;
      running_sum_q <= running_sum_d;
      res_cnt_q     <= res_cnt_d;
      res_done_q    <= res_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_type_q <= s_axis_tuser;
      in_len_q  <= s_axis_tdata[15:0];
      in_data_q <= s_axis_tdata[23:16];
    end
    res_q <= res_d;
  end

  `ECFE_ASSERT_SAME(a_done_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame_done off the last byte")
  `ECFE_ASSERT_SAME(a_open_has_left, clk_i, rst_ni, frame_open_q, bytes_left_q != '0, "open frame with no bytes left")
  `ECFE_ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, res_cnt_q <= CW'(MB), "result count overflow")

endmodule

// ===== tb/escaped_checksum_frame_encoder_test.sv =====
// Self-checking testbench for the escaped checksum frame encoder.
`timescale 1ns / 100ps

module escaped_checksum_frame_encoder_test;

  localparam int unsigned LEN_W = 16;
  localparam int RANDOM_ITEMS = 285;
  localparam int DRAIN_LIMIT = 20000;

  // One byte on the serial line with its flags.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       done;
  } line_byte_t;

  // One directed request, optionally with hand-written line bytes.
  typedef struct packed {
    logic            req;
    logic [15:0]     len;
    logic [7:0]      data;
    logic [0:7][7:0] fix;
    int              n_fix;    // -1: take the predicted bytes
    int              done_at;  // index of the checksum byte, -1 if none
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // frame_length[15:0], data_byte[23:16]
  logic        s_axis_tuser;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // out_byte[7:0]
  logic        m_axis_tlast;   // run_last
  logic        m_axis_tuser;   // frame_done

  escaped_checksum_frame_encoder #(
    .LENGTH_WIDTH(LEN_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // Framer state mirrored by the predictor.
  logic        fr_open;
  logic [15:0] fr_left;
  logic [7:0]  fr_sum;

  line_byte_t  encoded_q[$];   // bytes caused by the latest request
  line_byte_t  line_q[$];      // bytes still owed by the block
  plan_row_t   plan[$];

  bit quiet;                   // no idling on either side while set
  int fails;
  int items_sent, bytes_seen, frames_closed, stuffed_seen, dropped;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d bytes still owed", line_q.size());
    $display("escaped_checksum_frame_encoder: mismatch");
    $finish;
  end

  function automatic bit stuffed_code(input logic [7:0] b);
    return (b == 8'h02) || (b == 8'h03) || (b == 8'h05) || (b == 8'h06) ||
           (b == 8'h11) || (b == 8'h1b);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_line(input logic [7:0] b, input logic done);
    line_byte_t w;
    w.b = b;
    w.last = 1'b0;
    w.done = done;
    encoded_q.push_back(w);
  endtask

  task automatic put_stuffed(input logic [7:0] b, input logic done);
    if (stuffed_code(b)) begin
      put_line(ecfe_pkg::CODE_ESC, 1'b0);
      put_line(~b, done);
    end else begin
      put_line(b, done);
    end
  endtask

  task automatic close_frame();
    put_line(ecfe_pkg::CODE_ETX, 1'b0);
    fr_sum = fr_sum + ecfe_pkg::CODE_ETX;
    put_stuffed(fr_sum, 1'b1);
    fr_open = 1'b0;
    fr_left = '0;
    fr_sum = '0;
  endtask

  // Works out the line bytes for one request and advances the framer state.
  task automatic frame_encode(input logic req, input logic [15:0] len, input logic [7:0] data);
    logic [15:0] kept;
    line_byte_t  w;
    encoded_q.delete();
    kept = len & 16'((17'd1 << LEN_W) - 1);
    if (req == ecfe_pkg::REQ_START) begin
      fr_sum = kept[7:0] + kept[15:8];
      fr_left = kept;
      fr_open = 1'b1;
      put_line(ecfe_pkg::CODE_STX, 1'b0);
      put_stuffed(kept[7:0], 1'b0);
      put_stuffed(kept[15:8], 1'b0);
      if (fr_left == 0) close_frame();
    end else if (fr_open) begin
      fr_sum = fr_sum + data;
      put_stuffed(data, 1'b0);
      fr_left = fr_left - 1'b1;
      if (fr_left == 0) close_frame();
    end
    if (encoded_q.size() > 0) begin
      w = encoded_q.pop_back();
      w.last = 1'b1;
      encoded_q.push_back(w);
    end
  endtask

  // Offers one request after a random gap, then queues the bytes it owes.
  task automatic push_item(input logic req, input logic [15:0] len, input logic [7:0] data,
                           input int n_fix, input logic [0:7][7:0] fix, input int done_at,
                           output int produced);
    int gap;
    line_byte_t w;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser = req;
    s_axis_tdata = {data, len};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    frame_encode(req, len, data);
    if (n_fix >= 0) begin
      for (int i = 0; i < n_fix; i++) begin
        w.b = fix[i];
        w.last = (i == n_fix - 1);
        w.done = (i == done_at);
        line_q.push_back(w);
      end
      produced = n_fix;
    end else begin
      foreach (encoded_q[i]) line_q.push_back(encoded_q[i]);
      produced = encoded_q.size();
    end
    items_sent++;
    if (produced == 0) dropped++;
    @(negedge clk_i);
  endtask

  task automatic push_random(input logic req, input logic [15:0] len, input logic [7:0] data,
                             output int produced);
    push_item(req, len, data, -1, '0, -1, produced);
  endtask

  function automatic void add_row(input logic req, input logic [15:0] len,
                                  input logic [7:0] data, input int n_fix,
                                  input logic [0:7][7:0] fix, input int done_at);
    plan_row_t r;
    r.req = req;
    r.len = len;
    r.data = data;
    r.fix = fix;
    r.n_fix = n_fix;
    r.done_at = done_at;
    plan.push_back(r);
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] ctl [6];
    ctl = '{8'h02, 8'h03, 8'h05, 8'h06, 8'h11, 8'h1b};
    if ($urandom_range(0, 99) < 30) return ctl[$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  // Output side: random stalls, with quiet stretches.
  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        m_axis_tready = 1'b0;
        hold--;
      end else begin
        m_axis_tready = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : line_check
    line_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      bytes_seen++;
      if (m_axis_tdata == ecfe_pkg::CODE_ESC) stuffed_seen++;
      if (m_axis_tuser) frames_closed++;
      if (line_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("ERROR @%0t: unexpected byte %02h last=%b done=%b", $realtime,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = line_q.pop_front();
        if (m_axis_tdata !== want.b || m_axis_tlast !== want.last ||
            m_axis_tuser !== want.done) begin
          fails++;
          if (fails <= 10)
            $display("ERROR @%0t: expected %02h last=%b done=%b, got %02h last=%b done=%b",
                     $realtime, want.b, want.last, want.done,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    int produced, counted, waited, len, sent;
    logic [15:0] flen;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ecfe_pkg::REQ_START;
    quiet = 1'b0;
    fails = 0;
    items_sent = 0;
    bytes_seen = 0;
    frames_closed = 0;
    stuffed_seen = 0;
    dropped = 0;
    fr_open = 1'b0;
    fr_left = '0;
    fr_sum = '0;

    // Directed part: edges of every field, stuffing of each control byte,
    // dropped data, abandoned frames and the zero-length frame.
    add_row(ecfe_pkg::REQ_DATA, 16'hffff, 8'h5a, 0, '0, -1);   // no frame open yet
    add_row(ecfe_pkg::REQ_START, 16'h0000, 8'hff, 6,
            {8'h02, 8'h00, 8'h00, 8'h03, 8'h1b, 8'hfc, 8'h00, 8'h00}, 5);
    add_row(ecfe_pkg::REQ_START, 16'hffff, 8'hff, 3,
            {8'h02, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'h0000, 8'h00, -1, '0, -1);
    add_row(ecfe_pkg::REQ_START, 16'h1b02, 8'h00, 5,           // abandons the open frame
            {8'h02, 8'h1b, 8'hfd, 8'h1b, 8'he4, 8'h00, 8'h00, 8'h00}, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'hffff, 8'h03, -1, '0, -1);
    add_row(ecfe_pkg::REQ_START, 16'h0001, 8'h00, -1, '0, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'h0000, 8'hff, -1, '0, -1);  // checksum needs stuffing
    add_row(ecfe_pkg::REQ_START, 16'h0001, 8'hff, -1, '0, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'hffff, 8'h11, -1, '0, -1);
    add_row(ecfe_pkg::REQ_START, 16'h0002, 8'h00, -1, '0, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'h0000, 8'h06, -1, '0, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'hffff, 8'h05, -1, '0, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'h1234, 8'h5a, 0, '0, -1);   // frame already closed
    add_row(ecfe_pkg::REQ_START, 16'h0003, 8'h00, -1, '0, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'h0000, 8'h02, -1, '0, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'h0000, 8'h1b, -1, '0, -1);
    add_row(ecfe_pkg::REQ_DATA, 16'h0000, 8'h00, -1, '0, -1);
    add_row(ecfe_pkg::REQ_START, 16'h0605, 8'h00, 5,
            {8'h02, 8'h1b, 8'hfa, 8'h1b, 8'hf9, 8'h00, 8'h00, 8'h00}, -1);
    add_row(ecfe_pkg::REQ_START, 16'h0300, 8'h00, -1, '0, -1);
    add_row(ecfe_pkg::REQ_START, 16'h0000, 8'h00, 6,
            {8'h02, 8'h00, 8'h00, 8'h03, 8'h1b, 8'hfc, 8'h00, 8'h00}, 5);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i])
      push_item(plan[i].req, plan[i].len, plan[i].data, plan[i].n_fix, plan[i].fix,
                plan[i].done_at, produced);

    // Random part: mostly whole frames with random payload, some cut short,
    // some long headers, and stray data with no frame open.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 99) < 8) begin
        push_random(ecfe_pkg::REQ_DATA, 16'($urandom), payload_byte(), produced);
        if (produced > 0) counted++;
      end else begin
        case ($urandom_range(0, 19))
          0, 1:    flen = 16'($urandom);
          2:       flen = {8'($urandom), payload_byte()};
          3:       flen = {payload_byte(), payload_byte()};
          4, 5, 6: flen = 16'($urandom_range(5, 24));
          default: flen = 16'($urandom_range(0, 4));
        endcase
        push_random(ecfe_pkg::REQ_START, flen, 8'($urandom), produced);
        counted++;
        if (flen > 24) len = $urandom_range(0, 5);
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(0, flen);
        else len = flen;
        sent = 0;
        while (sent < len) begin
          push_random(ecfe_pkg::REQ_DATA, 16'($urandom), payload_byte(), produced);
          if (produced > 0) counted++;
          sent++;
        end
      end
    end
    quiet = 1'b0;
    s_axis_tvalid = 1'b0;

    waited = 0;
    while (line_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (line_q.size() != 0)
      $display("ERROR: %0d expected bytes never arrived", line_q.size());

    $display("Sent %0d requests (%0d dropped); checked %0d line bytes, %0d stuffed.",
             items_sent, dropped, bytes_seen, stuffed_seen);
    $display("Closed %0d frames; %0d errors.", frames_closed, fails);
    if (fails == 0 && line_q.size() == 0) begin
      $display("escaped_checksum_frame_encoder: match");
    end else begin
      $display("escaped_checksum_frame_encoder: mismatch");
    end
    $finish;
  end

endmodule
